// ----- rtl/tgq_pkg.sv -----
// ----------------------------------------------------------------------------
// tgq_pkg
// Shared types and constants of the text glyph quad generator.
// ----------------------------------------------------------------------------
package tgq_pkg;

  // Command codes carried in the lowest bits of the input beat.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_PLACE = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GLYPH_HEIGHT  = 2'd0,
    REG_SPACE_ADVANCE = 2'd1,
    REG_CHAR_GAP      = 2'd2
  } cfg_reg_e;

  localparam int unsigned GLYPH_COUNT_DEF   = 95;
  localparam int unsigned TEX_FRAC_BITS_DEF = 16;

  localparam logic [7:0] FIRST_CODE  = 8'd32;
  localparam logic [7:0] SPACE_CODE  = 8'd32;

  localparam logic [7:0] GLYPH_HEIGHT_RST  = 8'd16;
  localparam logic [7:0] SPACE_ADVANCE_RST = 8'd3;
  localparam logic [7:0] CHAR_GAP_RST      = 8'd1;

  // Six vertices per quad. Bit k selects the right edge (x) or the bottom
  // edge (y) for vertex k.
  localparam int unsigned VTX_COUNT = 6;
  localparam logic [VTX_COUNT-1:0] VTX_XSEL = 6'b110010;
  localparam logic [VTX_COUNT-1:0] VTX_YSEL = 6'b100110;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 56;

  // Geometry of one quad handed to the vertex generator.
  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic signed [16:0] y0;
    logic signed [16:0] y1;
    logic        [15:0] u_left;
    logic        [15:0] u_right;
  } quad_geom_t;

  // Add a non-negative amount to a signed 16-bit cursor, saturating at the
  // positive limit.
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] x,
                                                 input logic [8:0] a);
    logic signed [17:0] s;
    s = {{2{x[15]}}, x} + {9'd0, a};
    if (!s[17] && (s[16] || s[15])) begin
      sat_add = 16'sh7FFF;
    end else begin
      sat_add = s[15:0];
    end
  endfunction

endpackage

// ----- rtl/tgq_glyph_mem.sv -----
// ----------------------------------------------------------------------------
// tgq_glyph_mem
// Glyph table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tgq_glyph_mem #(
  parameter int unsigned DEPTH  = tgq_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned DATA_W = 2 * tgq_pkg::TEX_FRAC_BITS_DEF + 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tgq_vertex_gen.sv -----
// ----------------------------------------------------------------------------
// tgq_vertex_gen
// Steps through the six vertices of a quad into the output register.
// ----------------------------------------------------------------------------
module tgq_vertex_gen (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  tgq_pkg::quad_geom_t                  geom_i,
  output logic                                 ready_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pos_x[15:0], pos_y[32:16], tex_u[48:33], tex_v[49], zero pad[55:50]
  output logic [tgq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast
);

  tgq_pkg::quad_geom_t geom_q;
  logic                gen_valid_q;
  logic [2:0]          cnt_q;
  logic                out_valid_q;
  logic signed [15:0]  pos_x_q;
  logic signed [16:0]  pos_y_q;
  logic [15:0]         tex_u_q;
  logic                tex_v_q;
  logic                last_q;

  logic out_free;
  logic adv;
  logic at_last;
  logic xsel;
  logic ysel;

  assign out_free = !out_valid_q || m_axis_tready;
  assign adv      = gen_valid_q && out_free;
  assign at_last  = (cnt_q == 3'(tgq_pkg::VTX_COUNT - 1));
  assign ready_o  = !gen_valid_q || (adv && at_last);
  assign xsel     = tgq_pkg::VTX_XSEL[cnt_q];
  assign ysel     = tgq_pkg::VTX_YSEL[cnt_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (load_i) begin
      gen_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else if (adv) begin
      if (at_last) begin
        gen_valid_q <= 1'b0;
        cnt_q       <= '0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      geom_q <= geom_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= gen_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_q <= xsel ? geom_q.x1 : geom_q.x0;
      pos_y_q <= ysel ? geom_q.y1 : geom_q.y0;
      tex_u_q <= xsel ? geom_q.u_right : geom_q.u_left;
      tex_v_q <= ysel;
      last_q  <= at_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {6'd0, tex_v_q, tex_u_q, pos_y_q, pos_x_q};

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_valid_q |-> cnt_q < 3'(tgq_pkg::VTX_COUNT))
    else $error("vertex counter beyond the last vertex");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("quad loaded while the previous one is still being emitted");

  a_last_is_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> tex_v_q)
    else $error("final vertex of a quad is not on the bottom edge");
`endif

endmodule

// ----- rtl/text_glyph_quad_generator_unit.sv -----
// ----------------------------------------------------------------------------
// text_glyph_quad_generator_unit
// Turns a command stream of glyph loads, line starts and characters into the
// textured vertices of on-screen text, six vertices per drawn character.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as beats on the s_axis channel: a load writes one
// glyph table entry (left u, right u, pixel width), a start sets the cursor x
// and the line y, a place draws one printable character. A space only moves
// the cursor; characters outside the table and the unused command code are
// dropped. Each drawn character leaves as six vertex beats on m_axis, the
// sixth flagged with tlast. The three registers (glyph height, space advance
// and character gap) are written over the cfg channel, which is always ready
// and must only be used while the block is idle.
// A character beat enters the lookup stage at its accepting edge, is then
// loaded into the vertex stepper, and its first vertex is presented from the
// output register. One vertex leaves per cycle while the receiver is ready;
// loads, starts, spaces and dropped beats pass the lookup stage with no wait
// for the stepper. The six-step vertex counter sets the sustained rate.
// Reset clears the cursor and the line y to zero and the registers to 16, 3
// and 1. The glyph table is not cleared and must be loaded before use. When
// the receiver stalls, the output register holds its beat; the stepper and
// then the lookup stage back up, and s_axis_tready falls.
// ----------------------------------------------------------------------------
module text_glyph_quad_generator_unit #(
  parameter int unsigned GLYPH_COUNT   = tgq_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned TEX_FRAC_BITS = tgq_pkg::TEX_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Command stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // command[1:0], char_code[9:2], glyph_left[25:10], glyph_right[41:26],
  // glyph_width[49:42], start_x[65:50], start_y[81:66], zero pad[87:82]
  input  logic [tgq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Vertex stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pos_x[15:0], pos_y[32:16], tex_u[48:33], tex_v[49], zero pad[55:50]
  output logic [tgq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  // Register writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [7:0]                       cfg_data_i
);

  localparam int unsigned AddrW  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int unsigned UW     = TEX_FRAC_BITS;
  localparam int unsigned EntryW = 2 * UW + 8;
  localparam logic [8:0]  CountW = 9'(GLYPH_COUNT);

  // Input beat fields.
  logic [1:0]         in_cmd;
  logic [7:0]         in_code;
  logic [15:0]        in_left;
  logic [15:0]        in_right;
  logic [7:0]         in_width;
  logic signed [15:0] in_start_x;
  logic signed [15:0] in_start_y;

  assign in_cmd     = s_axis_tdata[1:0];
  assign in_code    = s_axis_tdata[9:2];
  assign in_left    = s_axis_tdata[25:10];
  assign in_right   = s_axis_tdata[41:26];
  assign in_width   = s_axis_tdata[49:42];
  assign in_start_x = s_axis_tdata[65:50];
  assign in_start_y = s_axis_tdata[81:66];

  logic       in_accept;
  logic [7:0] in_idx;
  logic       in_place_ok;
  logic       mem_we;
  logic       mem_re;

  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign in_idx      = in_code - tgq_pkg::FIRST_CODE;
  // A place is kept only when the character falls inside the table.
  assign in_place_ok = (in_code >= tgq_pkg::FIRST_CODE) && ({1'b0, in_idx} < CountW);
  assign mem_we      = in_accept && (in_cmd == tgq_pkg::CMD_LOAD) && ({1'b0, in_code} < CountW);
  assign mem_re      = in_accept && (in_cmd == tgq_pkg::CMD_PLACE) && in_place_ok;

  logic [EntryW-1:0] mem_wdata;
  logic [EntryW-1:0] mem_rdata;

  // Entry layout: width in the low byte, then right u, then left u.
  assign mem_wdata = {UW'(in_left), UW'(in_right), in_width};

  tgq_glyph_mem #(
    .DEPTH  (GLYPH_COUNT),
    .DATA_W (EntryW)
  ) u_glyph_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_code[AddrW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (in_idx[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Lookup stage: holds the command while the table read completes. All
  // cursor updates happen here, so they stay in command order.
  logic               b_valid_q;
  logic [1:0]         b_cmd_q;
  logic               b_ok_q;
  logic               b_space_q;
  logic signed [15:0] b_start_x_q;
  logic signed [15:0] b_start_y_q;

  logic signed [15:0] cursor_x_q;
  logic signed [15:0] line_y_q;
  logic [7:0]         glyph_height_q;
  logic [7:0]         space_advance_q;
  logic [7:0]         char_gap_q;

  logic [7:0]  rd_width;
  logic [15:0] rd_left;
  logic [15:0] rd_right;
  logic        b_place;
  logic        b_is_glyph;
  logic        b_take;
  logic        gen_ready;
  logic [8:0]  glyph_adv;

  tgq_pkg::quad_geom_t geom;

  assign rd_width = mem_rdata[7:0];
  assign rd_right = 16'(mem_rdata[UW+7:8]);
  assign rd_left  = 16'(mem_rdata[2*UW+7:UW+8]);

  assign b_place    = b_valid_q && (b_cmd_q == tgq_pkg::CMD_PLACE) && b_ok_q;
  assign b_is_glyph = b_place && !b_space_q;
  assign b_take     = b_valid_q && (!b_is_glyph || gen_ready);
  assign s_axis_tready = !b_valid_q || b_take;

  assign glyph_adv = {1'b0, rd_width} + {1'b0, char_gap_q};

  assign geom.x0      = cursor_x_q;
  assign geom.x1      = tgq_pkg::sat_add(cursor_x_q, {1'b0, rd_width});
  assign geom.y0      = {line_y_q[15], line_y_q};
  assign geom.y1      = {line_y_q[15], line_y_q} - {9'd0, glyph_height_q};
  assign geom.u_left  = rd_left;
  assign geom.u_right = rd_right;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      b_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_cmd_q     <= in_cmd;
      b_ok_q      <= in_place_ok;
      b_space_q   <= (in_code == tgq_pkg::SPACE_CODE);
      b_start_x_q <= in_start_x;
      b_start_y_q <= in_start_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      line_y_q   <= '0;
    end else if (b_take) begin
      if (b_cmd_q == tgq_pkg::CMD_START) begin
        cursor_x_q <= b_start_x_q;
        line_y_q   <= b_start_y_q;
      end else if (b_is_glyph) begin
        cursor_x_q <= tgq_pkg::sat_add(cursor_x_q, glyph_adv);
      end else if (b_place) begin
        cursor_x_q <= tgq_pkg::sat_add(cursor_x_q, {1'b0, space_advance_q});
      end
    end
  end

  // Register port: always ready, an index beyond the list is ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_height_q  <= tgq_pkg::GLYPH_HEIGHT_RST;
      space_advance_q <= tgq_pkg::SPACE_ADVANCE_RST;
      char_gap_q      <= tgq_pkg::CHAR_GAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tgq_pkg::REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data_i;
        tgq_pkg::REG_SPACE_ADVANCE: space_advance_q <= cfg_data_i;
        tgq_pkg::REG_CHAR_GAP:      char_gap_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tgq_vertex_gen u_vertex_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (b_take && b_is_glyph),
    .geom_i        (geom),
    .ready_o       (gen_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> b_valid_q && b_is_glyph)
    else $error("input stalled without a glyph waiting in the lookup stage");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> b_valid_q)
    else $error("accepted beat did not reach the lookup stage");

  a_start_sets_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_take && (b_cmd_q == tgq_pkg::CMD_START) |=>
      (cursor_x_q == $past(b_start_x_q)) && (line_y_q == $past(b_start_y_q)))
    else $error("start command did not set the cursor");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text glyph quad generator.
// ----------------------------------------------------------------------------
// A scripted opening walks loads, line starts, drawn characters, spaces and
// dropped beats at the field extremes. Random text under several register
// settings follows. Every accepted command beat goes through a local
// predictor of the cursor, the line and the glyph table. The vertices it
// predicts are compared field by field with the vertex beats that leave the
// block. Both stream sides idle at random, and the receiver holds off once
// for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned GLYPHS       = tgq_pkg::GLYPH_COUNT_DEF;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;  // command code the block drops
  localparam logic [1:0]  REG_UNUSED   = 2'd3;  // register index with no register
  localparam int          ITEMS_PER_PHASE = 50;
  localparam int          PHASES       = 6;
  localparam int          DRAIN_CYCLES = 8;     // lookup stage, vertex stepper and output register
  localparam int          DRAIN_LIMIT  = 20000;
  localparam int          CHOKE_CYCLES = 200;
  localparam int          PRINT_LIMIT  = 20;

  // Which corner each of the six vertices of a quad takes: bit k set means the
  // right edge (x and u) or the bottom edge (y and v) for vertex k.
  localparam logic [5:0] RIGHT_SIDE  = 6'b110010;
  localparam logic [5:0] BOTTOM_SIDE = 6'b100110;

  // One command beat, field by field.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         code;
    logic [15:0]        u_left;
    logic [15:0]        u_right;
    logic [7:0]         width;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } beat_t;

  // Quad typed into the script where it can be read off directly. When given
  // is clear the predictor supplies the vertices.
  typedef struct packed {
    bit                 given;
    bit                 draws;
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic signed [16:0] y0;
    logic signed [16:0] y1;
    logic [15:0]        u_l;
    logic [15:0]        u_r;
  } quad_t;

  typedef struct packed {
    beat_t b;
    quad_t q;
  } row_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [16:0] y;
    logic [15:0]        u;
    logic               v;
    logic               last;
  } vertex_t;

  localparam quad_t UNCHECKED   = '0;
  localparam quad_t NO_VERTICES = '{given: 1'b1, draws: 1'b0, x0: '0, x1: '0,
                                    y0: '0, y1: '0, u_l: '0, u_r: '0};

  // --------------------------------------------------------------------------
  // Signals of the block.
  // --------------------------------------------------------------------------
  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [tgq_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [tgq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [1:0]                      cfg_index_i;
  logic [7:0]                      cfg_data_i;

  text_glyph_quad_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of everything the block remembers.
  // --------------------------------------------------------------------------
  logic [15:0]        tbl_u_left  [GLYPHS];
  logic [15:0]        tbl_u_right [GLYPHS];
  logic [7:0]         tbl_width   [GLYPHS];
  logic signed [15:0] pen_x;
  logic signed [15:0] baseline_y;
  logic [7:0]         quad_height;
  logic [7:0]         space_step;
  logic [7:0]         glyph_gap;

  // Beats offered to the block, oldest first, and the vertices still owed.
  row_t    offered_q [$];
  vertex_t vertex_q  [$];

  // Glyph slots the stimulus has loaded so far; only these may be placed.
  bit      slot_loaded [GLYPHS];

  int      err_count;
  int      beats_taken;
  int      glyphs_drawn;
  int      vertices_seen;
  int      stall_cycles;
  int      tx_idle_pct;
  int      rx_idle_pct;
  bit      choke_req;

  // Scripted opening. The glyph for 'A' is loaded with the widest width and
  // the glyph for '~' with zero width, so that both saturation and a
  // degenerate quad show up. Rows with a typed quad are checked against it.
  row_t script [25] = '{
    // The space slot may be loaded but its entry is never used.
    '{'{tgq_pkg::CMD_LOAD, 8'd0, 16'hAAAA, 16'h5555, 8'd170, 16'h7FFF, 16'h8000}, UNCHECKED},
    '{'{tgq_pkg::CMD_LOAD, 8'd33, 16'h0000, 16'hFFFF, 8'd255, 16'sd0, 16'sd0}, UNCHECKED},
    '{'{tgq_pkg::CMD_LOAD, 8'd94, 16'hFFFF, 16'h0000, 8'd0, 16'sd0, 16'sd0}, UNCHECKED},
    // Load indexes beyond the table are dropped.
    '{'{tgq_pkg::CMD_LOAD, 8'd95, 16'h1234, 16'h4321, 8'd7, 16'sd0, 16'sd0}, UNCHECKED},
    '{'{tgq_pkg::CMD_LOAD, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF},
      UNCHECKED},
    // 'A' at the reset cursor and line, default height 16.
    '{'{tgq_pkg::CMD_PLACE, 8'd65, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0},
      '{1'b1, 1'b1, 16'sd0, 16'sd255, 17'sd0, -17'sd16, 16'h0000, 16'hFFFF}},
    '{'{tgq_pkg::CMD_PLACE, tgq_pkg::SPACE_CODE, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF,
        16'hFFFF}, NO_VERTICES},
    // '~' after 255 + gap 1 + space 3.
    '{'{tgq_pkg::CMD_PLACE, 8'd126, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0},
      '{1'b1, 1'b1, 16'sd259, 16'sd259, 17'sd0, -17'sd16, 16'hFFFF, 16'h0000}},
    // Characters outside the printable range and the unused command.
    '{'{tgq_pkg::CMD_PLACE, 8'd31, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0}, NO_VERTICES},
    '{'{tgq_pkg::CMD_PLACE, 8'd127, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0}, NO_VERTICES},
    '{'{tgq_pkg::CMD_PLACE, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF},
      NO_VERTICES},
    '{'{tgq_pkg::CMD_PLACE, 8'd0, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0}, NO_VERTICES},
    '{'{CMD_UNUSED, 8'd65, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF}, NO_VERTICES},
    // Cursor at the top of its range, line at the bottom of its range.
    '{'{tgq_pkg::CMD_START, 8'd0, 16'h0000, 16'h0000, 8'd0, 16'sh7FFF, 16'sh8000},
      NO_VERTICES},
    '{'{tgq_pkg::CMD_PLACE, 8'd65, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0},
      '{1'b1, 1'b1, 16'sd32767, 16'sd32767, -17'sd32768, -17'sd32784, 16'h0000, 16'hFFFF}},
    '{'{tgq_pkg::CMD_PLACE, tgq_pkg::SPACE_CODE, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0},
      NO_VERTICES},
    '{'{tgq_pkg::CMD_PLACE, 8'd126, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0}, UNCHECKED},
    // Cursor at the bottom of its range, line at the top.
    '{'{tgq_pkg::CMD_START, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 16'sh8000, 16'sh7FFF},
      NO_VERTICES},
    '{'{tgq_pkg::CMD_PLACE, 8'd65, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0},
      '{1'b1, 1'b1, -16'sd32768, -16'sd32513, 17'sd32767, 17'sd32751, 16'h0000, 16'hFFFF}},
    '{'{tgq_pkg::CMD_PLACE, 8'd65, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0}, UNCHECKED},
    '{'{tgq_pkg::CMD_START, 8'd0, 16'h0000, 16'h0000, 8'd0, 16'hFFFF, 16'hFFFF}, UNCHECKED},
    '{'{tgq_pkg::CMD_PLACE, tgq_pkg::SPACE_CODE, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0},
      UNCHECKED},
    '{'{tgq_pkg::CMD_PLACE, 8'd65, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0}, UNCHECKED},
    // Reloading a slot replaces its entry.
    '{'{tgq_pkg::CMD_LOAD, 8'd33, 16'h8000, 16'h7FFF, 8'd1, 16'sd0, 16'sd0}, UNCHECKED},
    '{'{tgq_pkg::CMD_PLACE, 8'd65, 16'h0000, 16'h0000, 8'd0, 16'sd0, 16'sd0}, UNCHECKED}
  };

  // --------------------------------------------------------------------------
  // Clock and time limit.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The limit lies far beyond the slowest correct run: under 300 beats with
  // six vertices each at the heaviest idling, plus the long hold-off.
  initial begin
    #3_000_000;
    $display("[text_glyph_quad_generator_unit] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Helpers.
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    if (err_count < PRINT_LIMIT) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  // Clamps a cursor sum at the positive end of the signed 16-bit range.
  function automatic logic signed [15:0] clamp_hi(input int v);
    return (v > 32767) ? 16'sh7FFF : v[15:0];
  endfunction

  // Advances the predictor by one accepted command beat and queues the
  // vertices it owes. A typed quad in the row replaces the predicted one,
  // while the cursor still moves as predicted.
  function automatic void predict_glyph_vertices(input row_t r);
    int                 slot;
    int                 k;
    bit                 draws;
    logic signed [15:0] x0, x1;
    logic signed [16:0] y0, y1;
    logic [15:0]        ul, ur;
    vertex_t            vtx;
    draws = 1'b0;
    x0 = '0; x1 = '0; y0 = '0; y1 = '0; ul = '0; ur = '0;
    case (r.b.cmd)
      tgq_pkg::CMD_LOAD: begin
        if (r.b.code < GLYPHS) begin
          tbl_u_left[r.b.code]  = r.b.u_left;
          tbl_u_right[r.b.code] = r.b.u_right;
          tbl_width[r.b.code]   = r.b.width;
        end
      end
      tgq_pkg::CMD_START: begin
        pen_x      = r.b.start_x;
        baseline_y = r.b.start_y;
      end
      tgq_pkg::CMD_PLACE: begin
        slot = int'(r.b.code) - int'(tgq_pkg::FIRST_CODE);
        if (slot == 0) begin
          pen_x = clamp_hi(int'(pen_x) + int'(space_step));
        end else if (slot > 0 && slot < GLYPHS) begin
          draws = 1'b1;
          x0 = pen_x;
          x1 = clamp_hi(int'(pen_x) + int'(tbl_width[slot]));
          y0 = 17'(baseline_y);
          y1 = 17'(int'(baseline_y) - int'(quad_height));
          ul = tbl_u_left[slot];
          ur = tbl_u_right[slot];
          pen_x = clamp_hi(int'(pen_x) + int'(tbl_width[slot]) + int'(glyph_gap));
        end
      end
      default: ;
    endcase
    if (r.q.given) begin
      draws = r.q.draws;
      x0 = r.q.x0; x1 = r.q.x1; y0 = r.q.y0; y1 = r.q.y1;
      ul = r.q.u_l; ur = r.q.u_r;
    end
    if (draws) begin
      glyphs_drawn++;
      for (k = 0; k < 6; k++) begin
        vtx.x    = RIGHT_SIDE[k]  ? x1 : x0;
        vtx.u    = RIGHT_SIDE[k]  ? ur : ul;
        vtx.y    = BOTTOM_SIDE[k] ? y1 : y0;
        vtx.v    = BOTTOM_SIDE[k];
        vtx.last = (k == 5);
        vertex_q.push_back(vtx);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Observation. Everything is sampled at the rising edge, so the values seen
  // are those that the handshake saw.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_streams
    vertex_t            want;
    logic signed [15:0] got_x;
    logic signed [16:0] got_y;
    logic [15:0]        got_u;
    if (rst_ni) begin
      // Vertex beats come from earlier commands, so they are checked first.
      if (m_axis_tvalid && m_axis_tready) begin
        vertices_seen++;
        got_x = m_axis_tdata[15:0];
        got_y = m_axis_tdata[32:16];
        got_u = m_axis_tdata[48:33];
        if (vertex_q.size() == 0) begin
          flag_error($sformatf("vertex beat x=%0d y=%0d with nothing owed", got_x, got_y));
        end else begin
          want = vertex_q.pop_front();
          if (got_x !== want.x)
            flag_error($sformatf("pos_x got %0d want %0d", got_x, want.x));
          if (got_y !== want.y)
            flag_error($sformatf("pos_y got %0d want %0d", got_y, want.y));
          if (got_u !== want.u)
            flag_error($sformatf("tex_u got %h want %h", got_u, want.u));
          if (m_axis_tdata[49] !== want.v)
            flag_error($sformatf("tex_v got %b want %b", m_axis_tdata[49], want.v));
          if (m_axis_tlast !== want.last)
            flag_error($sformatf("tlast got %b want %b", m_axis_tlast, want.last));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tgq_pkg::REG_GLYPH_HEIGHT:  quad_height = cfg_data_i;
          tgq_pkg::REG_SPACE_ADVANCE: space_step  = cfg_data_i;
          tgq_pkg::REG_CHAR_GAP:      glyph_gap   = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        stall_cycles++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beats_taken++;
        predict_glyph_vertices(offered_q.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Vertex receiver. It idles at the rate the current phase sets and, when
  // asked, holds off once for a long stretch, counting the cycles itself.
  // --------------------------------------------------------------------------
  initial begin : vertex_sink
    int hold;
    bit choked;
    m_axis_tready = 1'b0;
    choked = 1'b0;
    forever begin
      @(posedge clk_i);
      if (choke_req && !choked) begin
        choked = 1'b1;
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < CHOKE_CYCLES; hold++) begin
          @(posedge clk_i);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------

  // Offers one command beat, after any idle cycles, and returns at the edge
  // that accepts it. The valid stays high for a following beat.
  task automatic offer_command(input row_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, r.b.start_y, r.b.start_x, r.b.width, r.b.u_right,
                      r.b.u_left, r.b.code, r.b.cmd};
    offered_q.push_back(r);
    if (r.b.cmd == tgq_pkg::CMD_LOAD && r.b.code < GLYPHS) begin
      slot_loaded[r.b.code] = 1'b1;
    end
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Random text: mostly lines of loaded characters and spaces, with fresh
  // glyph loads and line starts mixed in, and a share of dropped beats.
  task automatic offer_random_text(input int count);
    row_t r;
    int   n;
    int   pick;
    int   slot;
    for (n = 0; n < count; n++) begin
      r.q = UNCHECKED;
      r.b.code    = 8'($urandom);
      r.b.u_left  = 16'($urandom);
      r.b.u_right = 16'($urandom);
      r.b.width   = 8'($urandom);
      r.b.start_x = 16'($urandom);
      r.b.start_y = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 15) begin
        r.b.cmd  = tgq_pkg::CMD_LOAD;
        r.b.code = ($urandom_range(9) == 0) ? 8'($urandom_range(255, GLYPHS))
                                            : 8'($urandom_range(GLYPHS - 1));
      end else if (pick < 25) begin
        r.b.cmd = tgq_pkg::CMD_START;
        // Often start near the right end so that the cursor clamps.
        if ($urandom_range(3) == 0) begin
          r.b.start_x = 16'sd32767 - 16'($urandom_range(600));
        end
      end else if (pick < 29) begin
        r.b.cmd = CMD_UNUSED;
      end else begin
        r.b.cmd = tgq_pkg::CMD_PLACE;
        pick = $urandom_range(99);
        if (pick < 12) begin
          r.b.code = tgq_pkg::SPACE_CODE;
        end else if (pick < 22) begin
          r.b.code = $urandom_range(1) ? 8'($urandom_range(31))
                                       : 8'($urandom_range(255, 127));
        end else begin
          do slot = $urandom_range(GLYPHS - 1, 1); while (!slot_loaded[slot]);
          r.b.code = 8'(slot) + tgq_pkg::FIRST_CODE;
        end
      end
      offer_command(r);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Register writes; the caller lowers the valid after the last one.
  task automatic write_register(input logic [1:0] index, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Waits until every offered beat is taken and every vertex has come back,
  // then lets the pipeline run dry. Anything still owed after the bound fails.
  task automatic drain_pipeline();
    int guard;
    guard = 0;
    while ((offered_q.size() != 0 || vertex_q.size() != 0) && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (offered_q.size() != 0 || vertex_q.size() != 0) begin
      flag_error($sformatf("%0d command beats and %0d vertices still outstanding",
                           offered_q.size(), vertex_q.size()));
      offered_q.delete();
      vertex_q.delete();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int           phase;
    logic [7:0]   height, advance, gap;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = tgq_pkg::REG_GLYPH_HEIGHT;
    cfg_data_i    = '0;
    choke_req     = 1'b0;
    tx_idle_pct   = 32;
    rx_idle_pct   = 47;
    err_count     = 0;
    beats_taken   = 0;
    glyphs_drawn  = 0;
    vertices_seen = 0;
    stall_cycles  = 0;
    pen_x         = '0;
    baseline_y    = '0;
    quad_height   = tgq_pkg::GLYPH_HEIGHT_RST;
    space_step    = tgq_pkg::SPACE_ADVANCE_RST;
    glyph_gap     = tgq_pkg::CHAR_GAP_RST;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted opening under the reset register values.
    foreach (script[i]) begin
      offer_command(script[i]);
    end
    s_axis_tvalid <= 1'b0;
    drain_pipeline();

    // Random phases. The first two keep the sender idling less than the
    // receiver, the next two swap that round, the last runs flat out.
    for (phase = 1; phase < PHASES; phase++) begin
      case (phase)
        1:       begin height = 8'd255; advance = 8'd255; gap = 8'd255; end
        2:       begin height = 8'd0;   advance = 8'd0;   gap = 8'd0;   end
        5:       begin height = 8'd255; advance = 8'd0;   gap = 8'd0;   end
        default: begin
          height  = 8'($urandom);
          advance = 8'($urandom);
          gap     = 8'($urandom);
        end
      endcase
      tx_idle_pct <= (phase < 3) ? 32 : (phase < 5) ? 47 : 0;
      rx_idle_pct <= (phase < 3) ? 47 : (phase < 5) ? 32 : 0;
      write_register(tgq_pkg::REG_GLYPH_HEIGHT, height);
      write_register(tgq_pkg::REG_SPACE_ADVANCE, advance);
      write_register(tgq_pkg::REG_CHAR_GAP, gap);
      // A write to the index with no register behind it must change nothing.
      if (phase == 1) begin
        write_register(REG_UNUSED, 8'hFF);
      end
      cfg_valid_i <= 1'b0;
      // With the sender flat out, a long hold-off backs the block up.
      if (phase == 5) begin
        choke_req <= 1'b1;
      end
      offer_random_text(ITEMS_PER_PHASE);
      drain_pipeline();
    end

    $display("Run covered %0d command beats, %0d glyphs drawn and %0d vertex beats",
             beats_taken, glyphs_drawn, vertices_seen);
    $display("over %0d register settings; the input was held back on %0d cycles.",
             PHASES, stall_cycles);
    if (err_count == 0) begin
      $display("[text_glyph_quad_generator_unit] OK");
    end else begin
      $display("[text_glyph_quad_generator_unit] ERROR");
    end
    $finish;
  end

endmodule
